// ----- design/hbs_pkg.sv -----
// Height-map bilinear sampler: shared constants, codes and item types.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package hbs_pkg;

  // Grid and store limits
  localparam int MaxWidth   = 64;
  localparam int MaxDepth   = 64;
  localparam int StoreDepth = 4096;
  localparam int AddrW      = $clog2(StoreDepth);

  // Field widths
  localparam int GridW    = 7;
  localparam int TileW    = 6;
  localparam int TpuW     = 24;
  localparam int HeightW  = 16;
  localparam int PosW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Fixed-point: position Q16.16 times scale Q8.16 gives 32 fraction bits
  localparam int FracBits  = 16;
  localparam int ProdFrac  = 32;
  localparam int ProdW     = PosW + TpuW + 1;
  localparam int TileFullW = ProdW - ProdFrac + 1;
  localparam int WeightW   = FracBits + 2;
  localparam int RowW      = HeightW + WeightW;
  localparam int BlendW    = RowW + WeightW;

  // Queue between front and back end
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Number of neighbourhood taps
  localparam int NumTaps = 4;

  typedef enum logic {
    FuncWrite  = 1'b0,
    FuncSample = 1'b1
  } hbs_func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridWidth    = 3'd0,
    CfgGridDepth    = 3'd1,
    CfgCentreX      = 3'd2,
    CfgCentreZ      = 3'd3,
    CfgTilesPerUnit = 3'd4
  } hbs_cfg_e;

  // Input item
  typedef struct packed {
    hbs_func_e                 func;
    logic [AddrW-1:0]          cell_index;
    logic signed [HeightW-1:0] height_in;
    logic signed [PosW-1:0]    pos_x;
    logic signed [PosW-1:0]    pos_z;
  } hbs_req_t;

  // Result item
  typedef struct packed {
    logic signed [HeightW-1:0] height_out;
    logic                      outside;
  } hbs_res_t;

  // Configuration register set
  typedef struct packed {
    logic [GridW-1:0] grid_width;
    logic [GridW-1:0] grid_depth;
    logic [TileW-1:0] centre_x;
    logic [TileW-1:0] centre_z;
    logic [TpuW-1:0]  tiles_per_unit;
  } hbs_cfg_t;

  // Classified item travelling from front to back end
  typedef struct packed {
    hbs_func_e           func;
    logic                outside;
    logic [AddrW-1:0]    addr;
    logic [GridW-1:0]    width;
    logic [FracBits-1:0] fx;
    logic [FracBits-1:0] fz;
    logic [HeightW-1:0]  data;
  } hbs_qent_t;

  // Queue status seen by the front end
  typedef struct packed {
    logic [QCntW-1:0] count;
  } hbs_qstat_t;

endpackage

`default_nettype wire

// ----- design/heightmap_bilinear_sampler.sv -----
// A sample passes the two front stages, the queue and back-end stages s0 to s3 before its result is registered.
// Throughput: one item per cycle; writes give no result. busy only rises if the
// front stages and the four-entry queue together hold four items, which the back end
// (one pop per cycle) never lets happen, so a steady stream is taken every cycle.
// Reset clears the pipeline and sets the registers to their defaults; the store is
// not cleared and must be written before use.
`default_nettype none

module heightmap_bilinear_sampler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  hbs_pkg::hbs_req_t             req_i,
  output logic                          res_valid_o,
  output hbs_pkg::hbs_res_t             res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hbs_pkg::CfgDataW-1:0]  cfg_data_i
);

  hbs_pkg::hbs_cfg_t   cfg_q;
  hbs_pkg::hbs_qstat_t qstat;
  hbs_pkg::hbs_qent_t  push, head;
  logic                push_valid, head_valid, pop;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width     <= hbs_pkg::GridW'(64);
      cfg_q.grid_depth     <= hbs_pkg::GridW'(64);
      cfg_q.centre_x       <= hbs_pkg::TileW'(32);
      cfg_q.centre_z       <= hbs_pkg::TileW'(32);
      cfg_q.tiles_per_unit <= hbs_pkg::TpuW'(65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hbs_pkg::CfgGridWidth:    cfg_q.grid_width     <= cfg_data_i[hbs_pkg::GridW-1:0];
        hbs_pkg::CfgGridDepth:    cfg_q.grid_depth     <= cfg_data_i[hbs_pkg::GridW-1:0];
        hbs_pkg::CfgCentreX:      cfg_q.centre_x       <= cfg_data_i[hbs_pkg::TileW-1:0];
        hbs_pkg::CfgCentreZ:      cfg_q.centre_z       <= cfg_data_i[hbs_pkg::TileW-1:0];
        hbs_pkg::CfgTilesPerUnit: cfg_q.tiles_per_unit <= cfg_data_i[hbs_pkg::TpuW-1:0];
        default: ;
      endcase
    end
  end

  hbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_i        (req_i),
    .busy_o       (busy),
    .cfg_i        (cfg_q),
    .qstat_i      (qstat),
    .push_valid_o (push_valid),
    .push_o       (push)
  );

  hbs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .qstat_o      (qstat)
  );

  hbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

// ----- design/hbs_front.sv -----
// Front end: accepts items, scales positions to tiles, classifies the neighbourhood.
// Depends on hbs_pkg.
`default_nettype none

module hbs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  hbs_pkg::hbs_req_t  req_i,
  output logic               busy_o,
  input  hbs_pkg::hbs_cfg_t  cfg_i,
  input  hbs_pkg::hbs_qstat_t qstat_i,
  output logic               push_valid_o,
  output hbs_pkg::hbs_qent_t push_o
);

  logic accept;

  // Stage 1: scale products
  logic                                   f1_valid_q;
  hbs_pkg::hbs_func_e                     f1_func_q;
  logic [hbs_pkg::AddrW-1:0]              f1_index_q;
  logic [hbs_pkg::HeightW-1:0]            f1_height_q;
  logic signed [hbs_pkg::ProdW-1:0]       px_d, pz_d, px_q, pz_q;

  // Stage 2: tile, fraction and classification
  logic signed [hbs_pkg::TileFullW-1:0]   tx_full, tz_full, wm2, dm2;
  logic [hbs_pkg::GridW-1:0]              w_eff, d_eff;
  logic                                   out_d;
  logic                                   f2_valid_q;
  hbs_pkg::hbs_func_e                     f2_func_q;
  logic                                   f2_out_q;
  logic [hbs_pkg::TileW-1:0]              f2_tx_q, f2_tz_q;
  logic [hbs_pkg::FracBits-1:0]           f2_fx_q, f2_fz_q;
  logic [hbs_pkg::GridW-1:0]              f2_w_q;
  logic [hbs_pkg::AddrW-1:0]              f2_index_q;
  logic [hbs_pkg::HeightW-1:0]            f2_height_q;
  logic [hbs_pkg::TileW+hbs_pkg::GridW-1:0] row_base;

  // Credit: items in flight in the front plus queue fill must leave room
  logic [hbs_pkg::QCntW:0] occ;

  always_comb begin
    occ = (hbs_pkg::QCntW+1)'(qstat_i.count) + (hbs_pkg::QCntW+1)'(f1_valid_q)
        + (hbs_pkg::QCntW+1)'(f2_valid_q);
  end

  assign busy_o = (occ >= (hbs_pkg::QCntW+1)'(hbs_pkg::QDepth));
  assign accept = start_i && !busy_o;

  // Position times scale, signed by unsigned
  always_comb begin
    px_d = $signed(req_i.pos_x) * $signed({1'b0, cfg_i.tiles_per_unit});
    pz_d = $signed(req_i.pos_z) * $signed({1'b0, cfg_i.tiles_per_unit});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_func_q   <= req_i.func;
      f1_index_q  <= req_i.cell_index;
      f1_height_q <= req_i.height_in;
      px_q        <= px_d;
      pz_q        <= pz_d;
    end
  end

  // Floor to tile (arithmetic shift), add centre, clamp grid size, range check
  always_comb begin
    tx_full = $signed({px_q[hbs_pkg::ProdW-1], px_q[hbs_pkg::ProdW-1:hbs_pkg::ProdFrac]})
            + $signed(hbs_pkg::TileFullW'(cfg_i.centre_x));
    tz_full = $signed({pz_q[hbs_pkg::ProdW-1], pz_q[hbs_pkg::ProdW-1:hbs_pkg::ProdFrac]})
            + $signed(hbs_pkg::TileFullW'(cfg_i.centre_z));
    w_eff = (cfg_i.grid_width > hbs_pkg::GridW'(hbs_pkg::MaxWidth)) ?
            hbs_pkg::GridW'(hbs_pkg::MaxWidth) : cfg_i.grid_width;
    d_eff = (cfg_i.grid_depth > hbs_pkg::GridW'(hbs_pkg::MaxDepth)) ?
            hbs_pkg::GridW'(hbs_pkg::MaxDepth) : cfg_i.grid_depth;
    wm2 = $signed(hbs_pkg::TileFullW'(w_eff)) - $signed(hbs_pkg::TileFullW'(2));
    dm2 = $signed(hbs_pkg::TileFullW'(d_eff)) - $signed(hbs_pkg::TileFullW'(2));
    out_d = (w_eff < hbs_pkg::GridW'(2)) || (d_eff < hbs_pkg::GridW'(2))
         || tx_full[hbs_pkg::TileFullW-1] || (tx_full > wm2)
         || tz_full[hbs_pkg::TileFullW-1] || (tz_full > dm2);
  end

  always_ff @(posedge clk_i) begin
    if (f1_valid_q) begin
      f2_func_q   <= f1_func_q;
      f2_out_q    <= out_d;
      f2_tx_q     <= tx_full[hbs_pkg::TileW-1:0];
      f2_tz_q     <= tz_full[hbs_pkg::TileW-1:0];
      f2_fx_q     <= px_q[hbs_pkg::ProdFrac-1 -: hbs_pkg::FracBits];
      f2_fz_q     <= pz_q[hbs_pkg::ProdFrac-1 -: hbs_pkg::FracBits];
      f2_w_q      <= w_eff;
      f2_index_q  <= f1_index_q;
      f2_height_q <= f1_height_q;
    end
  end

  // Row-major base of the neighbourhood, or the write address
  always_comb begin
    row_base            = f2_tz_q * f2_w_q;
    push_o.func         = f2_func_q;
    push_o.outside      = f2_out_q;
    push_o.width        = f2_w_q;
    push_o.fx           = f2_fx_q;
    push_o.fz           = f2_fz_q;
    push_o.data         = f2_height_q;
    if (f2_func_q == hbs_pkg::FuncWrite) begin
      push_o.addr = f2_index_q;
    end else begin
      push_o.addr = row_base[hbs_pkg::AddrW-1:0] + hbs_pkg::AddrW'(f2_tx_q);
    end
  end

  assign push_valid_o = f2_valid_q;

endmodule

`default_nettype wire

// ----- design/hbs_fifo.sv -----
// Short queue of classified items between front and back end.
// Depends on hbs_pkg.
`default_nettype none

module hbs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  hbs_pkg::hbs_qent_t  push_i,
  input  logic                pop_i,
  output logic                head_valid_o,
  output hbs_pkg::hbs_qent_t  head_o,
  output hbs_pkg::hbs_qstat_t qstat_o
);

  hbs_pkg::hbs_qent_t          ent_q [hbs_pkg::QDepth];
  logic [hbs_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hbs_pkg::QCntW-1:0]   count_q, count_d;
  logic                        do_pop;

  assign head_valid_o  = (count_q != '0);
  assign head_o        = ent_q[rd_ptr_q];
  assign do_pop        = pop_i && head_valid_o;
  assign qstat_o.count = count_q;

  always_comb begin
    count_d = count_q;
    if (push_valid_i && !do_pop) begin
      count_d = count_q + hbs_pkg::QCntW'(1);
    end else if (!push_valid_i && do_pop) begin
      count_d = count_q - hbs_pkg::QCntW'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_valid_i) begin
        wr_ptr_q <= wr_ptr_q + hbs_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + hbs_pkg::QPtrW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      ent_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/hbs_back.sv -----
// Back end: height store (one copy per tap), four-tap read and bilinear blend pipeline.
// Depends on hbs_pkg.
`default_nettype none

module hbs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  hbs_pkg::hbs_qent_t head_i,
  output logic               pop_o,
  output logic               res_valid_o,
  output hbs_pkg::hbs_res_t  res_o
);

  localparam logic [hbs_pkg::FracBits:0] One = (hbs_pkg::FracBits+1)'(1) << hbs_pkg::FracBits;

  logic                      wr_en, rd_en;
  logic [hbs_pkg::AddrW-1:0] tap_addr [hbs_pkg::NumTaps];
  logic [hbs_pkg::HeightW-1:0] rd_q   [hbs_pkg::NumTaps];

  // Stage 0: read issue
  logic                         s0_valid_q, s0_out_q;
  logic [hbs_pkg::FracBits-1:0] s0_fx_q, s0_fz_q;
  // Stage 1: tap products
  logic                         s1_valid_q, s1_out_q;
  logic [hbs_pkg::FracBits-1:0] s1_fz_q;
  logic signed [hbs_pkg::WeightW-1:0] wx0, wx1, wz0, wz1;
  logic signed [hbs_pkg::RowW-1:0] p_d [hbs_pkg::NumTaps];
  logic signed [hbs_pkg::RowW-1:0] p_q [hbs_pkg::NumTaps];
  // Stage 2: row blends
  logic                         s2_valid_q, s2_out_q;
  logic [hbs_pkg::FracBits-1:0] s2_fz_q;
  logic signed [hbs_pkg::RowW-1:0] r0_q, r1_q;
  // Stage 3: column products
  logic                         s3_valid_q, s3_out_q;
  logic signed [hbs_pkg::BlendW-1:0] c0_q, c1_q;
  // Stage 4: sum and truncate
  logic signed [hbs_pkg::BlendW-1:0] blend;
  logic [hbs_pkg::HeightW-1:0]       trunc;
  logic                              res_valid_q;
  hbs_pkg::hbs_res_t                 res_d, res_q;

  // Back end never stalls: take the head whenever there is one
  assign pop_o = head_valid_i;
  assign wr_en = head_valid_i && (head_i.func == hbs_pkg::FuncWrite);
  assign rd_en = head_valid_i && (head_i.func == hbs_pkg::FuncSample);

  // Neighbourhood addresses, wrapping at the store size
  always_comb begin
    tap_addr[0] = head_i.addr;
    tap_addr[1] = head_i.addr + hbs_pkg::AddrW'(1);
    tap_addr[2] = head_i.addr + hbs_pkg::AddrW'(head_i.width);
    tap_addr[3] = head_i.addr + hbs_pkg::AddrW'(head_i.width) + hbs_pkg::AddrW'(1);
  end

  // One store copy per tap, all written together
  for (genvar k = 0; k < hbs_pkg::NumTaps; k++) begin : g_store
    logic [hbs_pkg::HeightW-1:0] store_q [hbs_pkg::StoreDepth];

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        store_q[head_i.addr] <= head_i.data;
      end
      if (rd_en) begin
        rd_q[k] <= store_q[tap_addr[k]];
      end
    end
  end

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= rd_en;
      s1_valid_q  <= s0_valid_q;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      res_valid_q <= s3_valid_q;
    end
  end

  // Weights: one minus fraction, and fraction
  always_comb begin
    wx0 = $signed(hbs_pkg::WeightW'(One - (hbs_pkg::FracBits+1)'(s0_fx_q)));
    wx1 = $signed(hbs_pkg::WeightW'(s0_fx_q));
    wz0 = $signed(hbs_pkg::WeightW'(One - (hbs_pkg::FracBits+1)'(s2_fz_q)));
    wz1 = $signed(hbs_pkg::WeightW'(s2_fz_q));
    p_d[0] = $signed(rd_q[0]) * wx0;
    p_d[1] = $signed(rd_q[1]) * wx1;
    p_d[2] = $signed(rd_q[2]) * wx0;
    p_d[3] = $signed(rd_q[3]) * wx1;
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s0_out_q <= head_i.outside;
      s0_fx_q  <= head_i.fx;
      s0_fz_q  <= head_i.fz;
    end
    if (s0_valid_q) begin
      s1_out_q <= s0_out_q;
      s1_fz_q  <= s0_fz_q;
      for (int i = 0; i < hbs_pkg::NumTaps; i++) begin
        p_q[i] <= p_d[i];
      end
    end
    if (s1_valid_q) begin
      s2_out_q <= s1_out_q;
      s2_fz_q  <= s1_fz_q;
      r0_q     <= p_q[0] + p_q[1];
      r1_q     <= p_q[2] + p_q[3];
    end
    if (s2_valid_q) begin
      s3_out_q <= s2_out_q;
      c0_q     <= r0_q * wz0;
      c1_q     <= r1_q * wz1;
    end
    if (s3_valid_q) begin
      res_q <= res_d;
    end
  end

  // Final sum, truncation toward zero, outside forces zero
  always_comb begin
    blend = c0_q + c1_q;
    trunc = blend[2*hbs_pkg::FracBits +: hbs_pkg::HeightW];
    if (blend[hbs_pkg::BlendW-1] && (blend[2*hbs_pkg::FracBits-1:0] != '0)) begin
      trunc = trunc + hbs_pkg::HeightW'(1);
    end
    res_d.outside    = s3_out_q;
    res_d.height_out = s3_out_q ? '0 : $signed(trunc);
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- design/hbs_checker.sv -----
// Port-level checks on the sampler: fixed result latency, silent writes, no spurious results and outside results.
// Depends on hbs_pkg; bound to heightmap_bilinear_sampler.
`default_nettype none

module hbs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input hbs_pkg::hbs_req_t            req_i,
  input logic                         res_valid_o,
  input hbs_pkg::hbs_res_t            res_o
);

  logic sample_acc, write_acc;

  assign sample_acc = start && !busy && (req_i.func == hbs_pkg::FuncSample);
  assign write_acc  = start && !busy && (req_i.func == hbs_pkg::FuncWrite);

  // Every accepted sample produces a result strobe on res_valid_o
  a_sample_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_acc |-> ##8 res_valid_o)
    else $error("sample item gave no result at the expected cycle");

  // A write item never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_acc |-> ##8 !res_valid_o)
    else $error("write item produced a result");

  // A result strobe always traces back to an accepted sample
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(sample_acc, 8))
    else $error("result without a matching sample item");

  // Outside samples report zero height
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.outside) |-> (res_o.height_out == '0))
    else $error("outside result with nonzero height");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);

`default_nettype wire
